/* src/key_press_classifier_defines.svh */
// Assertion macros for the key press classifier.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef KEY_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

`define KPC_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("key press classifier check failed");

`define KPC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key press classifier check failed");

`define KPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key press classifier check failed");

`else

`define KPC_ASSERT(lbl, cond)
`define KPC_ASSERT_IMPL(lbl, ante, cons)
`define KPC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/kpc_pkg.sv */
package kpc_pkg;

	localparam int LIMIT_W     = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WINDOW = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESS_LEVEL   = 2'd2;

	localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RESET    = 8'd100;
	localparam logic [LIMIT_W-1:0] DOUBLE_WINDOW_RESET = 8'd10;
	localparam logic               PRESS_LEVEL_RESET   = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PRESSED,
		PH_WINDOW,
		PH_WAIT_RELEASE
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_SINGLE,
		EV_DOUBLE,
		EV_HOLD
	} event_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] hold_limit;
		logic [LIMIT_W-1:0] double_window;
		logic               press_level;
	} cfg_t;

endpackage

/* src/kpc_fsm.sv */
`include "key_press_classifier_defines.svh"

module kpc_fsm #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            key_level,
	input  kpc_pkg::cfg_t   cfg,
	output kpc_pkg::event_t key_event
);

	localparam int CMP_W = (COUNT_WIDTH > kpc_pkg::LIMIT_W) ? COUNT_WIDTH : kpc_pkg::LIMIT_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

	kpc_pkg::phase_t         phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]  count_q, count_d;
	logic [COUNT_WIDTH-1:0]  count_inc;
	logic                    pressed;

	// A count at the top of its range ends the phase even below the limit.
	function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
		input logic [kpc_pkg::LIMIT_W-1:0] limit);
		reached = (CMP_W'(c) >= CMP_W'(limit)) || (c == COUNT_MAX);
	endfunction

	assign pressed   = (key_level == cfg.press_level);
	assign count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + COUNT_ONE;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		key_event = kpc_pkg::EV_NONE;
		case (phase_q)
			kpc_pkg::PH_IDLE: begin
				if (pressed) begin
					count_d = COUNT_ONE;
					if (reached(COUNT_ONE, cfg.hold_limit)) begin
						key_event = kpc_pkg::EV_HOLD;
						phase_d   = kpc_pkg::PH_WAIT_RELEASE;
					end else begin
						phase_d = kpc_pkg::PH_PRESSED;
					end
				end
			end
			kpc_pkg::PH_PRESSED: begin
				if (pressed) begin
					count_d = count_inc;
					if (reached(count_inc, cfg.hold_limit)) begin
						key_event = kpc_pkg::EV_HOLD;
						phase_d   = kpc_pkg::PH_WAIT_RELEASE;
					end
				end else begin
					count_d = '0;
					phase_d = kpc_pkg::PH_WINDOW;
				end
			end
			kpc_pkg::PH_WINDOW: begin
				count_d = count_inc;
				if (pressed) begin
					key_event = kpc_pkg::EV_DOUBLE;
					phase_d   = kpc_pkg::PH_WAIT_RELEASE;
				end else if (reached(count_inc, cfg.double_window)) begin
					key_event = kpc_pkg::EV_SINGLE;
					count_d   = '0;
					phase_d   = kpc_pkg::PH_IDLE;
				end
			end
			kpc_pkg::PH_WAIT_RELEASE: begin
				if (!pressed) begin
					count_d = '0;
					phase_d = kpc_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = kpc_pkg::PH_IDLE;
				count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kpc_pkg::PH_IDLE;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	`KPC_ASSERT_IMPL(a_idle_count_clear, phase_q == kpc_pkg::PH_IDLE, count_q == '0)
	`KPC_ASSERT_IMPL(a_pressed_count_set, phase_q == kpc_pkg::PH_PRESSED, count_q != '0)
	`KPC_ASSERT_IMPL(a_double_from_window, step && key_event == kpc_pkg::EV_DOUBLE, phase_q == kpc_pkg::PH_WINDOW)
	`KPC_ASSERT_NEXT(a_hold_then_wait, step && key_event == kpc_pkg::EV_HOLD, phase_q == kpc_pkg::PH_WAIT_RELEASE)

endmodule

/* src/key_press_classifier.sv */
// Key press classifier: one sampled key level per timer tick in, one event out.
// Input channel: in_valid/in_ready with key_level. Output channel:
// out_valid/out_ready with key_event (none, single click, double click, hold).
// Every accepted item gives exactly one result item, in order.
// Configuration registers (hold_limit, double_window, press_level) are written
// through cfg_wen/cfg_index/cfg_wdata; the user must do so only while no item is
// in flight, as the block does not enforce it. There are two register stages: an
// accepted item sits in the input register, and the phase and tick counter logic
// loads the result register from it once that register is free or being taken.
// One item per cycle while out_ready stays high; the phase register and counter
// update once for each item that moves into the result register.
// When the receiver holds out_ready low, the result stays in its register and
// one more item waits in the input register; in_ready then drops.
// Reset clears both registers' valid flags, returns the phase to idle with the
// counter at zero, and loads the register reset values (100, 10, high level).
module key_press_classifier #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               key_level,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         key_event,
	input  logic                               cfg_wen,
	input  logic [kpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [kpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	kpc_pkg::cfg_t   cfg_q;
	logic            valid_s1;
	logic            key_s1;
	logic            out_valid_q;
	kpc_pkg::event_t event_q;
	kpc_pkg::event_t event_d;
	logic            advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign key_event = event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_limit    <= kpc_pkg::HOLD_LIMIT_RESET;
			cfg_q.double_window <= kpc_pkg::DOUBLE_WINDOW_RESET;
			cfg_q.press_level   <= kpc_pkg::PRESS_LEVEL_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				kpc_pkg::REG_HOLD_LIMIT:    cfg_q.hold_limit    <= cfg_wdata;
				kpc_pkg::REG_DOUBLE_WINDOW: cfg_q.double_window <= cfg_wdata;
				kpc_pkg::REG_PRESS_LEVEL:   cfg_q.press_level   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_s1 <= key_level;
		end
		if (advance) begin
			event_q <= event_d;
		end
	end

	kpc_fsm #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.key_level (key_s1),
		.cfg       (cfg_q),
		.key_event (event_d)
	);

endmodule

/* tb/tb_key_press_classifier.sv */
class key_event_board;
	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	logic [kpc_pkg::LIMIT_W-1:0] hold_limit;
	logic [kpc_pkg::LIMIT_W-1:0] double_window;
	logic                        press_level;
	kpc_pkg::phase_t             phase;
	logic [CNT_W-1:0]            tick_count;
	kpc_pkg::event_t             expected_events[$];
	int                          errors;

	function new();
		hold_limit    = kpc_pkg::HOLD_LIMIT_RESET;
		double_window = kpc_pkg::DOUBLE_WINDOW_RESET;
		press_level   = kpc_pkg::PRESS_LEVEL_RESET;
		phase         = kpc_pkg::PH_IDLE;
		tick_count    = '0;
		errors        = 0;
	endfunction

	function void set_reg(logic [kpc_pkg::CFG_INDEX_W-1:0] idx,
		logic [kpc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			kpc_pkg::REG_HOLD_LIMIT: begin
				hold_limit = data;
			end
			kpc_pkg::REG_DOUBLE_WINDOW: begin
				double_window = data;
			end
			kpc_pkg::REG_PRESS_LEVEL: begin
				press_level = data[0];
			end
			default: begin
			end
		endcase
	endfunction

	function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	// A saturated counter counts as having reached any limit.
	function bit hit(logic [CNT_W-1:0] c, logic [kpc_pkg::LIMIT_W-1:0] lim);
		return (c >= lim) || (c == CNT_MAX);
	endfunction

	function void note_key(logic lvl);
		logic            pressed;
		kpc_pkg::event_t ev;
		pressed = (lvl == press_level);
		ev = kpc_pkg::EV_NONE;
		case (phase)
			kpc_pkg::PH_IDLE: begin
				if (pressed) begin
					tick_count = bump('0);
					if (hit(tick_count, hold_limit)) begin
						ev = kpc_pkg::EV_HOLD;
						phase = kpc_pkg::PH_WAIT_RELEASE;
					end else begin
						phase = kpc_pkg::PH_PRESSED;
					end
				end
			end
			kpc_pkg::PH_PRESSED: begin
				if (pressed) begin
					tick_count = bump(tick_count);
					if (hit(tick_count, hold_limit)) begin
						ev = kpc_pkg::EV_HOLD;
						phase = kpc_pkg::PH_WAIT_RELEASE;
					end
				end else begin
					tick_count = '0;
					phase = kpc_pkg::PH_WINDOW;
				end
			end
			kpc_pkg::PH_WINDOW: begin
				tick_count = bump(tick_count);
				if (pressed) begin
					ev = kpc_pkg::EV_DOUBLE;
					phase = kpc_pkg::PH_WAIT_RELEASE;
				end else if (hit(tick_count, double_window)) begin
					ev = kpc_pkg::EV_SINGLE;
					tick_count = '0;
					phase = kpc_pkg::PH_IDLE;
				end
			end
			default: begin
				if (!pressed) begin
					tick_count = '0;
					phase = kpc_pkg::PH_IDLE;
				end
			end
		endcase
		expected_events.push_back(ev);
	endfunction

	function void check_event(logic [1:0] actual);
		kpc_pkg::event_t want;
		if (expected_events.size() == 0) begin
			$error("key_event: no item expected, got %0d", actual);
			errors++;
		end else begin
			want = expected_events.pop_front();
			if (actual !== want) begin
				$error("key_event: expected %0d, got %0d", want, actual);
				errors++;
			end
		end
	endfunction

	function int pending();
		return expected_events.size();
	endfunction
endclass

module tb_key_press_classifier;
	localparam int CNT_W = 8;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 100;
	localparam logic [kpc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            key_level = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [1:0]                      key_event;
	logic                            cfg_wen = 1'b0;
	logic [kpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [kpc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	key_event_board board = new();

	int unsigned burst_left = 0;
	int          phase_items = 0;
	int          idle_cycles = 0;
	bit          hold_off_req = 0;
	int          cur_hold = 100;
	int          cur_win = 10;
	logic        cur_level = 1'b1;

	key_press_classifier #(
		.COUNT_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key_level(key_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_event(key_event),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			board.check_event(key_event);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Receiver: stretches of always-ready, coin-flip and sparse readiness, with one long
	// hold-off on request so the block backs up into its input.
	initial begin
		int unsigned stretch_left;
		int unsigned mode;
		stretch_left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 0;
			end else begin
				if (stretch_left == 0) begin
					mode = $urandom_range(0, 2);
					stretch_left = $urandom_range(1, 60);
				end
				stretch_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_key(input logic lvl);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		key_level <= lvl;
		do @(posedge clk); while (!in_ready);
		board.note_key(lvl);
		burst_left--;
		phase_items++;
	endtask

	// Sends n ticks that are pressed or released under the current press level.
	task automatic press_run(input bit pressed, input int n);
		repeat (n) send_key(pressed ? cur_level : ~cur_level);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [kpc_pkg::CFG_INDEX_W-1:0] idx,
		input logic [kpc_pkg::CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic write_config(input int hold, input int win, input logic [7:0] lvl_data);
		put_reg(kpc_pkg::REG_HOLD_LIMIT, hold[7:0]);
		put_reg(kpc_pkg::REG_DOUBLE_WINDOW, win[7:0]);
		put_reg(kpc_pkg::REG_PRESS_LEVEL, lvl_data);
		// The spare index must leave every register alone.
		put_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
		cfg_wen <= 1'b0;
		cur_hold = (hold[7:0] == 8'd0) ? 1 : int'(hold[7:0]);
		cur_win = (win[7:0] == 8'd0) ? 1 : int'(win[7:0]);
		cur_level = lvl_data[0];
	endtask

	// Press shorter than the hold limit (one tick when the limit is 1); mostly up to six ticks, now and then any length.
	function automatic int short_press();
		int lim;
		lim = (cur_hold > 1) ? cur_hold - 1 : 1;
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(1, lim);
		end
		return $urandom_range(1, (lim < 6) ? lim : 6);
	endfunction

	task automatic play_gesture();
		int unsigned kind;
		int          gap;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			press_run(1, short_press());
			gap = ($urandom_range(0, 3) == 0) ? cur_win + 1 : $urandom_range(1, 6);
			press_run(0, gap);
		end else if (kind <= 5) begin
			press_run(1, short_press());
			press_run(0, $urandom_range(1, (cur_win < 6) ? cur_win : 6));
			press_run(1, short_press());
			press_run(0, $urandom_range(1, 3));
		end else if (kind <= 7) begin
			press_run(1, cur_hold + $urandom_range(0, 4));
			press_run(0, $urandom_range(1, 4));
		end else begin
			repeat ($urandom_range(1, 10)) send_key(1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int          hold_set[PHASES];
		int          win_set[PHASES];
		logic [7:0]  lvl_set[PHASES];
		hold_set = '{255, 1, 100, 2, 5, 255, 1, 0, 0, 0};
		win_set  = '{255, 1, 10, 0, 3, 1, 255, 0, 0, 0};
		lvl_set  = '{8'h01, 8'h00, 8'h01, 8'h80, 8'h03, 8'hFF, 8'h7E, 8'h00, 8'h00, 8'h00};
		for (int p = 7; p < PHASES; p++) begin
			hold_set[p] = (p == PHASES - 1) ? $urandom_range(0, 255) : $urandom_range(1, 16);
			win_set[p] = $urandom_range(0, 16);
			lvl_set[p] = 8'($urandom_range(0, 255));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single click, double click, hold, release while idle, and a second
		// press on the last tick of the window.
		write_config(3, 2, 8'h01);
		press_run(1, 1);
		press_run(0, 3);
		press_run(1, 1);
		press_run(0, 1);
		press_run(1, 1);
		press_run(0, 1);
		press_run(1, 4);
		press_run(0, 2);
		press_run(1, 1);
		press_run(0, 2);
		press_run(1, 1);
		press_run(0, 1);
		drain();

		// Zero limits behave like one; press level comes from the low data bit only.
		write_config(0, 0, 8'hFE);
		press_run(1, 1);
		press_run(0, 1);
		press_run(1, 2);
		press_run(0, 1);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_config(hold_set[p], win_set[p], lvl_set[p]);
			if (p == 3) begin
				hold_off_req = 1;
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) play_gesture();
			drain();
		end

		repeat (10) @(posedge clk);
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+src
src/kpc_pkg.sv
src/kpc_fsm.sv
src/key_press_classifier.sv
tb/tb_key_press_classifier.sv
